@@ hw/rtl/rgbpx_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpx_pkg
// shared types and constants for the rgb16 pixel blend / darken / pack unit
// ----------------------------------------------------------------------------
package rgbpx_pkg;

   localparam int unsigned PIXEL_W   = 16;
   localparam int unsigned COMP_W    = 8;
   localparam int unsigned RATIO_W   = 5;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned CHAN_W    = 6;   // widest channel (565 green)

   localparam logic [RATIO_W-1:0] RATIO_FULL  = 5'd16;
   localparam int unsigned        RATIO_SHIFT = 4;

   localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DARKEN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PACK   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PIXEL_W-1:0] pixel_a;
      logic [PIXEL_W-1:0] pixel_b;
      logic [RATIO_W-1:0] ratio;
      logic [COMP_W-1:0]  amount;
      logic [COMP_W-1:0]  red_in;
      logic [COMP_W-1:0]  green_in;
      logic [COMP_W-1:0]  blue_in;
   } req_item_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

endpackage

@@ hw/rtl/rgb16_pixel_blend_darken_pack_top.sv @@
// ----------------------------------------------------------------------------
// rgb16_pixel_blend_darken_pack_top
// 16-bit rgb pixel unit: blend two pixels, darken one, or pack 8-bit components
// ----------------------------------------------------------------------------
//
//   channel | ports        | handshake        | payload
//   --------+--------------+------------------+-------------------------------
//   request | req_*        | valid / ready    | mode, pixels, ratio, amount, rgb
//   response| rsp_*        | valid / ready    | pixel_out
//   csr     | csr_*        | write enable     | format_565 (1 = 565, 0 = 555)
//
// two register stages: input register, then one pass of channel arithmetic
// into the result register; one transaction per cycle sustained while the
// response is taken. the multipliers of the blend path (6 x 5 bit) set the
// critical path. reset clears both valid flags and sets the layout to 565. a
// stalled response holds its stage; the input stage still fills behind it, so
// ready drops only when both stages are full and the response is not taken.
// ----------------------------------------------------------------------------
module rgb16_pixel_blend_darken_pack_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rgbpx_pkg::MODE_W-1:0]      req_mode,
   input  logic [rgbpx_pkg::PIXEL_W-1:0]     req_pixel_a,
   input  logic [rgbpx_pkg::PIXEL_W-1:0]     req_pixel_b,
   input  logic [rgbpx_pkg::RATIO_W-1:0]     req_ratio,
   input  logic [rgbpx_pkg::COMP_W-1:0]      req_amount,
   input  logic [rgbpx_pkg::COMP_W-1:0]      req_red_in,
   input  logic [rgbpx_pkg::COMP_W-1:0]      req_green_in,
   input  logic [rgbpx_pkg::COMP_W-1:0]      req_blue_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rgbpx_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);
   import rgbpx_pkg::*;

   // layout register
   logic         format_ff;
   logic         format_in;

   // input stage
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   req_item_type in_item_in;

   // result stage
   logic         out_valid_ff;
   logic         out_valid_in;
   pixel_type    out_pixel_ff;
   pixel_type    out_pixel_in;

   pixel_type    alu_pixel;
   logic         out_free;
   logic         in_move;
   logic         req_take;

   // result stage can take a new value when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_move   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   rgbpx_alu u_alu (
      .item       (in_item_ff),
      .format_565 (format_ff),
      .pixel_out  (alu_pixel)
   );

   always_comb begin
      format_in = csr_wr_en ? csr_wr_data : format_ff;

      // input register refills whenever it empties or hands on its transaction
      in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_item_in.mode     = req_mode;
         in_item_in.pixel_a  = req_pixel_a;
         in_item_in.pixel_b  = req_pixel_b;
         in_item_in.ratio    = req_ratio;
         in_item_in.amount   = req_amount;
         in_item_in.red_in   = req_red_in;
         in_item_in.green_in = req_green_in;
         in_item_in.blue_in  = req_blue_in;
      end

      // result register
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
      out_pixel_in = in_move ? alu_pixel : out_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pixel_ff;

endmodule

@@ hw/rtl/rgbpx_alu.sv @@
// ----------------------------------------------------------------------------
// rgbpx_alu
// combinational pixel operation: blend, darken or pack in 565 / 555 layout
// ----------------------------------------------------------------------------
module rgbpx_alu (
   input  rgbpx_pkg::req_item_type item,
   input  logic                    format_565,
   output rgbpx_pkg::pixel_type    pixel_out
);
   import rgbpx_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
   } chan_type;

   chan_type           ca;
   chan_type           cb;
   chan_type           res;
   logic [RATIO_W-1:0] w;
   logic [RATIO_W-1:0] w_inv;

   // unpack a pixel into zero-extended channels, top bit ignored in 555
   function automatic chan_type split(input pixel_type p, input logic f565);
      chan_type c;
      c.r = f565 ? {1'b0, p[15:11]} : {1'b0, p[14:10]};
      c.g = f565 ? p[10:5] : {1'b0, p[9:5]};
      c.b = {1'b0, p[4:0]};
      return c;
   endfunction

   // (x*w + y*(16-w)) >> 4, at most 63*16 so ten bits hold it
   function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] x,
                                             input logic [CHAN_W-1:0] y,
                                             input logic [RATIO_W-1:0] wa,
                                             input logic [RATIO_W-1:0] wb);
      logic [9:0] acc;
      acc = 10'(x) * 10'(wa) + 10'(y) * 10'(wb);
      return acc[RATIO_SHIFT +: CHAN_W];
   endfunction

   function automatic logic [CHAN_W-1:0] floor_sub(input logic [CHAN_W-1:0] x,
                                                   input logic [COMP_W-1:0] d);
      logic [COMP_W-1:0] xe;
      logic [COMP_W-1:0] diff;
      xe   = COMP_W'(x);
      diff = xe - d;
      return (xe > d) ? diff[CHAN_W-1:0] : '0;
   endfunction

   always_comb begin
      ca    = split(item.pixel_a, format_565);
      cb    = split(item.pixel_b, format_565);
      w     = (item.ratio > RATIO_FULL) ? RATIO_FULL : item.ratio;
      w_inv = RATIO_FULL - w;
      res   = '0;
      case (item.mode)
         MODE_BLEND: begin
            res.r = mix(ca.r, cb.r, w, w_inv);
            res.g = mix(ca.g, cb.g, w, w_inv);
            res.b = mix(ca.b, cb.b, w, w_inv);
         end
         MODE_DARKEN: begin
            res.r = floor_sub(ca.r, item.amount);
            res.g = floor_sub(ca.g, item.amount);
            res.b = floor_sub(ca.b, item.amount);
         end
         MODE_PACK: begin
            res.r = {1'b0, item.red_in[7:3]};
            res.g = format_565 ? item.green_in[7:2] : {1'b0, item.green_in[7:3]};
            res.b = {1'b0, item.blue_in[7:3]};
         end
         default: begin
            res = '0;
         end
      endcase
      if (item.mode == MODE_NONE) begin
         pixel_out = '0;
      end else if (format_565) begin
         pixel_out = {res.r[4:0], res.g[5:0], res.b[4:0]};
      end else begin
         pixel_out = {1'b0, res.r[4:0], res.g[4:0], res.b[4:0]};
      end
   end

endmodule

@@ hw/rtl/rgbpx_chk.sv @@
// ----------------------------------------------------------------------------
// rgbpx_chk
// port-level checks for the pixel unit, bound to the top level
// ----------------------------------------------------------------------------
module rgbpx_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rgbpx_pkg::PIXEL_W-1:0] rsp_pixel_out
);
   import rgbpx_pkg::*;

   // transactions inside the unit, at most two
   logic [1:0] occ_ff;
   logic [1:0] occ_in;

   always_comb begin
      occ_in = occ_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // a held response keeps its pixel
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("response changed while stalled");

   // no response appears without a transaction inside
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != 2'd0)
      else $error("response without a pending transaction");

   // never more than two transactions in flight
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff != 2'd3)
      else $error("more than two transactions in flight");

   // a unit that is not full always takes a request
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      occ_ff != 2'd2 |-> req_ready)
      else $error("request stalled with room in the pipeline");

   // full with a stalled response must push back
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      occ_ff == 2'd2 && !rsp_ready |-> !req_ready)
      else $error("request taken while full");

endmodule

bind rgb16_pixel_blend_darken_pack_top rgbpx_chk u_rgbpx_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out)
);

@@ tb/tb_rgb16_pixel_blend_darken_pack_top.sv @@
// ----------------------------------------------------------------------------
// tb_rgb16_pixel_blend_darken_pack_top
// self-checking bench for the 16-bit rgb blend / darken / pack unit
// ----------------------------------------------------------------------------
// a stimulus process queues pixel transactions per layout phase; a clocked
// driver offers them with random gaps and predicts each accepted one, and a
// clocked monitor takes results with random back-pressure and compares them
// in order against the predicted pixels
// ----------------------------------------------------------------------------
module tb_rgb16_pixel_blend_darken_pack_top;

   timeunit 1ns;
   timeprecision 1ps;

   import rgbpx_pkg::*;

   localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
   localparam int WATCHDOG_MAX  = 2000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 10;    // pipeline is two stages deep

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic [MODE_W-1:0]  req_mode     = MODE_BLEND;
   logic [PIXEL_W-1:0] req_pixel_a  = '0;
   logic [PIXEL_W-1:0] req_pixel_b  = '0;
   logic [RATIO_W-1:0] req_ratio    = '0;
   logic [COMP_W-1:0]  req_amount   = '0;
   logic [COMP_W-1:0]  req_red_in   = '0;
   logic [COMP_W-1:0]  req_green_in = '0;
   logic [COMP_W-1:0]  req_blue_in  = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic [PIXEL_W-1:0] rsp_pixel_out;
   logic               csr_wr_en    = 1'b0;
   logic               csr_wr_data  = 1'b0;

   // bench copy of the layout register, 565 out of reset
   bit layout_565 = 1'b1;

   // pending transactions, predicted pixels and bookkeeping
   req_item_type pending_items[$];
   pixel_type    expected_pixels[$];
   req_item_type held_item;
   int           queued_count   = 0;
   int           accepted_count = 0;
   int           result_count   = 0;
   int           error_count    = 0;

   // idling state of both sides
   int send_gap  = 0;
   int send_calm = 0;
   int recv_gap  = 0;
   int recv_calm = 0;
   int idle_cycles = 0;
   pixel_type want_pixel;

   rgb16_pixel_blend_darken_pack_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_pixel_a   (req_pixel_a),
      .req_pixel_b   (req_pixel_b),
      .req_ratio     (req_ratio),
      .req_amount    (req_amount),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // pixel predictor: channel split by layout, per-channel arithmetic, repack
   // ---------------------------------------------------------------------
   function automatic pixel_type predict_pixel(req_item_type t, bit is565);
      int unsigned gbits, gmask, rpos, w, w_inv, amt;
      int unsigned ar, ag, ab, br, bg, bb;
      int unsigned r, g, b;
      gbits = is565 ? 6 : 5;
      gmask = (1 << gbits) - 1;
      rpos  = 5 + gbits;
      // ratio saturates at full weight
      w     = (t.ratio > RATIO_FULL) ? 32'(RATIO_FULL) : 32'(t.ratio);
      w_inv = 32'(RATIO_FULL) - w;
      amt   = 32'(t.amount);
      // the spare top bit in 555 falls outside every channel mask
      ar = (32'(t.pixel_a) >> rpos) & 31;
      ag = (32'(t.pixel_a) >> 5) & gmask;
      ab = 32'(t.pixel_a) & 31;
      br = (32'(t.pixel_b) >> rpos) & 31;
      bg = (32'(t.pixel_b) >> 5) & gmask;
      bb = 32'(t.pixel_b) & 31;
      r = 0;
      g = 0;
      b = 0;
      case (t.mode)
         MODE_BLEND: begin
            r = (ar * w + br * w_inv) >> RATIO_SHIFT;
            g = (ag * w + bg * w_inv) >> RATIO_SHIFT;
            b = (ab * w + bb * w_inv) >> RATIO_SHIFT;
         end
         MODE_DARKEN: begin
            r = (ar > amt) ? ar - amt : 0;
            g = (ag > amt) ? ag - amt : 0;
            b = (ab > amt) ? ab - amt : 0;
         end
         MODE_PACK: begin
            r = 32'(t.red_in) >> 3;
            g = 32'(t.green_in) >> (COMP_W - gbits);
            b = 32'(t.blue_in) >> 3;
         end
         default: begin
            // undefined mode gives a black pixel
         end
      endcase
      return pixel_type'((((r & 31) << rpos) | ((g & gmask) << 5) | (b & 31)) & 16'hFFFF);
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_item_type make_item(logic [MODE_W-1:0] m, pixel_type pa,
                                              pixel_type pb, logic [RATIO_W-1:0] w,
                                              logic [COMP_W-1:0] amt, logic [COMP_W-1:0] r,
                                              logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
      req_item_type t;
      t.mode     = m;
      t.pixel_a  = pa;
      t.pixel_b  = pb;
      t.ratio    = w;
      t.amount   = amt;
      t.red_in   = r;
      t.green_in = g;
      t.blue_in  = b;
      return t;
   endfunction

   // pixels lean towards the all-zero and all-one corners now and then
   function automatic pixel_type random_pixel();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 16'h0000;
      else if (pick == 1)
         return 16'hFFFF;
      return pixel_type'($urandom_range(0, 65535));
   endfunction

   function automatic req_item_type random_item();
      req_item_type t;
      int unsigned pick;
      t.pixel_a = random_pixel();
      t.pixel_b = random_pixel();
      pick = $urandom_range(0, 19);
      if (pick < 6)
         t.mode = MODE_BLEND;
      else if (pick < 12)
         t.mode = MODE_DARKEN;
      else if (pick < 18)
         t.mode = MODE_PACK;
      else
         t.mode = MODE_NONE;
      // mostly legal weights, some above full to hit saturation
      if ($urandom_range(0, 99) < 85)
         t.ratio = RATIO_W'($urandom_range(0, 16));
      else
         t.ratio = RATIO_W'($urandom_range(17, 31));
      pick = $urandom_range(0, 9);
      if (pick < 3)
         t.amount = COMP_W'($urandom_range(0, 31));     // partial darkening
      else if (pick == 3)
         t.amount = 8'hFF;
      else if (pick == 4)
         t.amount = 8'h00;
      else
         t.amount = COMP_W'($urandom_range(0, 255));
      t.red_in   = COMP_W'($urandom_range(0, 255));
      t.green_in = COMP_W'($urandom_range(0, 255));
      t.blue_in  = COMP_W'($urandom_range(0, 255));
      return t;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   task automatic queue_item(req_item_type t);
      pending_items.push_back(t);
      queued_count++;
   endtask

   task automatic queue_random(int n);
      repeat (n) queue_item(random_item());
   endtask

   // sender pause: every queued transaction accepted and every result back
   task automatic wait_drained();
      while (accepted_count != queued_count || expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   // layout change, only while the unit is empty
   task automatic write_layout(bit is565);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= is565;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      layout_565 = is565;
   endtask

   // ---------------------------------------------------------------------
   // driver: offers pending transactions, predicts each accepted one
   // ---------------------------------------------------------------------
   bit offer_now;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer_now = req_valid;
         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_pixel(held_item, layout_565));
            accepted_count++;
            offer_now = 1'b0;
            // calm stretches give back-to-back transactions
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = draw_gap();
               if ($urandom_range(0, 31) == 0)
                  send_calm = $urandom_range(20, 80);
            end
         end
         if (!offer_now) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_items.size() != 0) begin
               held_item    = pending_items.pop_front();
               offer_now    = 1'b1;
               req_mode     <= held_item.mode;
               req_pixel_a  <= held_item.pixel_a;
               req_pixel_b  <= held_item.pixel_b;
               req_ratio    <= held_item.ratio;
               req_amount   <= held_item.amount;
               req_red_in   <= held_item.red_in;
               req_green_in <= held_item.green_in;
               req_blue_in  <= held_item.blue_in;
            end
         end
         req_valid <= offer_now;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random back-pressure, in-order compare of every result
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual pixel_out %h",
                        $time, rsp_pixel_out);
               error_count++;
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_pixel_out !== want_pixel) begin
                  $display("%0t: pixel_out mismatch, expected %h, actual %h",
                           $time, want_pixel, rsp_pixel_out);
                  error_count++;
               end
            end
            if (recv_calm > 0) begin
               recv_calm--;
               recv_gap = 0;
            end else begin
               recv_gap = draw_gap();
               if ($urandom_range(0, 31) == 0)
                  recv_calm = $urandom_range(20, 80);
            end
            // long hold-off so both stages fill and the input stalls
            if (result_count == 150 || result_count == 700)
               recv_gap = HOLD_CYCLES;
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: too long without any handshake ends the run
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_MAX) begin
         $display("%0t: watchdog expired, %0d results still outstanding",
                  $time, expected_pixels.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 565 layout out of reset: weight extremes, saturation, floors, packing
      queue_item(make_item(MODE_BLEND,  16'hFFFF, 16'h0000, 5'd0,  8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'hFFFF, 16'h0000, 5'd16, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'h1234, 16'hABCD, 5'd31, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'h0000, 16'hFFFF, 5'd17, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'hFFFF, 16'hFFFF, 5'd8,  8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_item(make_item(MODE_DARKEN, 16'hFFFF, 16'hFFFF, 5'd31, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_DARKEN, 16'hFFFF, 16'h0000, 5'd0,  8'hFF, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_DARKEN, 16'h8410, 16'h0000, 5'd0,  8'd10, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_PACK,   16'h0000, 16'h0000, 5'd0,  8'h00, 8'hFF, 8'hFF, 8'hFF));
      queue_item(make_item(MODE_PACK,   16'hFFFF, 16'hFFFF, 5'd31, 8'hFF, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_PACK,   16'h0000, 16'h0000, 5'd0,  8'h00, 8'h80, 8'h04, 8'h07));
      queue_item(make_item(MODE_NONE,   16'hFFFF, 16'hFFFF, 5'd31, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_item(make_item(MODE_BLEND,  16'hF800, 16'h07E0, 5'd5,  8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_random(300);

      // 555 layout: the spare top bit must be ignored and come out as zero
      write_layout(1'b0);
      queue_item(make_item(MODE_BLEND,  16'h8000, 16'hFFFF, 5'd5,  8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'hFFFF, 16'h0000, 5'd16, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_BLEND,  16'h7FFF, 16'h8000, 5'd20, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_DARKEN, 16'hFFFF, 16'h0000, 5'd0,  8'd3,  8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_DARKEN, 16'h7FFF, 16'h0000, 5'd0,  8'd31, 8'h00, 8'h00, 8'h00));
      queue_item(make_item(MODE_PACK,   16'hFFFF, 16'hFFFF, 5'd0,  8'h00, 8'hFF, 8'hFF, 8'hFF));
      queue_item(make_item(MODE_PACK,   16'h0000, 16'h0000, 5'd0,  8'h00, 8'h7F, 8'h80, 8'h08));
      queue_item(make_item(MODE_NONE,   16'h8000, 16'h8000, 5'd16, 8'h01, 8'h01, 8'h01, 8'h01));
      queue_random(300);

      // back to 565, with a full pause of the sender half way
      write_layout(1'b1);
      queue_random(150);
      wait_drained();
      queue_random(150);

      write_layout(1'b0);
      queue_random(200);

      write_layout(1'b1);
      queue_random(150);

      // everything accepted and answered, then let the pipeline settle
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $display("%0t: %0d results never arrived, expected %h, actual none",
                  $time, expected_pixels.size(), expected_pixels[0]);
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rgbpx_pkg.sv
hw/rtl/rgbpx_alu.sv
hw/rtl/rgb16_pixel_blend_darken_pack_top.sv
hw/rtl/rgbpx_chk.sv
tb/tb_rgb16_pixel_blend_darken_pack_top.sv
